>>> rtl/core/bdr_pkg.sv
package bdr_pkg;

    localparam int DIM_W   = 11;
    localparam int ADJ_W   = 4;
    localparam int PER_W   = 7;
    localparam int COLOR_W = 8;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 2;
    localparam int SCALE_W = 6;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int QUEUE_DEPTH = 4;

    localparam int LIMIT_WIDTH  = 180;
    localparam int LIMIT_HEIGHT = 150;
    // width / 160 = ((width >> 5) * 205) >> 10, exact for width below 4128
    localparam int COL_SHIFT   = 5;
    localparam int RECIP5      = 205;
    localparam int RECIP_SHIFT = 10;
    // height / 128
    localparam int ROW_SHIFT   = 7;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_SCALE_ADJUST = 2'd2,
        REG_FIX_PERIOD   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [ADJ_W-1:0] scale_adjust;
        logic [PER_W-1:0] fix_period;
    } cfg_t;

    localparam cfg_t RESET_CFG = '{
        image_width:  11'd160,
        image_height: 11'd128,
        scale_adjust: 4'd1,
        fix_period:   7'd0
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              dup;
    } entry_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

>>> rtl/core/bdr_front.sv
module bdr_front #(
    parameter int MAX_WIDTH  = bdr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bdr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bdr_pkg::cfg_t                cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bdr_pkg::COLOR_W-1:0]  s_blue,
    input  logic [bdr_pkg::COLOR_W-1:0]  s_green,
    input  logic [bdr_pkg::COLOR_W-1:0]  s_red,
    input  logic                         s_first_pixel,
    input  bdr_pkg::queue_status_t       q_status,
    output logic                         push,
    output bdr_pkg::entry_t              push_entry
);
    import bdr_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = (WW > DIM_W) ? WW : DIM_W;
    localparam int HCMP = (HW > DIM_W) ? HW : DIM_W;
    localparam int SUMW = ((WCMP > HCMP) ? WCMP : HCMP) + SCALE_W + 2;
    localparam int PRDW = WCMP + 8;

    typedef struct packed {
        logic [WW-1:0]      w;
        logic [HW-1:0]      h;
        logic               scaled;
        logic [SCALE_W-1:0] scale;
    } geom_t;

    function automatic geom_t derive(input cfg_t c);
        logic [WCMP-1:0]    w_ext;
        logic [HCMP-1:0]    h_ext;
        logic [WCMP-1:0]    wc;
        logic [HCMP-1:0]    hc;
        logic [PRDW-1:0]    prod;
        logic [SCALE_W-1:0] a;
        logic [SCALE_W-1:0] b;
        logic [SCALE_W-1:0] mx;
        logic [SCALE_W-1:0] sum;
        geom_t              g;
        w_ext = WCMP'(c.image_width);
        h_ext = HCMP'(c.image_height);
        if (w_ext == '0) begin
            wc = WCMP'(1);
        end else if (w_ext > WCMP'(MAX_WIDTH)) begin
            wc = WCMP'(MAX_WIDTH);
        end else begin
            wc = w_ext;
        end
        if (h_ext == '0) begin
            hc = HCMP'(1);
        end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
            hc = HCMP'(MAX_HEIGHT);
        end else begin
            hc = h_ext;
        end
        prod = PRDW'(wc >> COL_SHIFT) * PRDW'(RECIP5);
        a    = SCALE_W'(prod >> RECIP_SHIFT);
        b    = SCALE_W'(hc >> ROW_SHIFT);
        mx   = (a > b) ? a : b;
        sum  = mx + SCALE_W'(c.scale_adjust);
        g.w      = WW'(wc);
        g.h      = HW'(hc);
        g.scaled = (wc > WCMP'(LIMIT_WIDTH)) || (hc > HCMP'(LIMIT_HEIGHT));
        if (!g.scaled || sum == '0) begin
            g.scale = SCALE_W'(1);
        end else begin
            g.scale = sum;
        end
        return g;
    endfunction

    geom_t              geom;
    logic [CW-1:0]      column_count_reg, column_count_next;
    logic [RW-1:0]      row_count_reg, row_count_next;
    logic [SCALE_W-1:0] column_phase_reg, column_phase_next;
    logic [SCALE_W-1:0] row_phase_reg, row_phase_next;
    logic [PER_W-1:0]   fix_counter_reg, fix_counter_next;
    logic               image_done_reg, image_done_next;

    logic [CW-1:0]      cc;
    logic [RW-1:0]      rc;
    logic [SCALE_W-1:0] cp;
    logic [SCALE_W-1:0] rp;
    logic [PER_W-1:0]   fc;
    logic               done;

    logic [SUMW-1:0]    cc_s, cc_2s, rc_s, w_s, h_s, scale_s, cc_1, rc_1;
    logic               row_ok, emit_sc, last_kept, empty_row, period_on;
    logic [PER_W:0]     fc_inc, fc0_inc;
    logic [PER_W-1:0]   fc_after, fc0, fc_before;
    logic [SCALE_W:0]   cp_inc, rp_inc;
    logic               emit, dup, accept;

    assign geom    = derive(cfg);
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cc   = s_first_pixel ? '0 : column_count_reg;
        rc   = s_first_pixel ? '0 : row_count_reg;
        cp   = s_first_pixel ? '0 : column_phase_reg;
        rp   = s_first_pixel ? '0 : row_phase_reg;
        fc   = s_first_pixel ? '0 : fix_counter_reg;
        done = s_first_pixel ? 1'b0 : image_done_reg;

        w_s     = SUMW'(geom.w);
        h_s     = SUMW'(geom.h);
        scale_s = SUMW'(geom.scale);
        cc_s    = SUMW'(cc) + scale_s;
        cc_2s   = SUMW'(cc) + (scale_s << 1);
        rc_s    = SUMW'(rc) + scale_s;
        cc_1    = SUMW'(cc) + SUMW'(1);
        rc_1    = SUMW'(rc) + SUMW'(1);

        row_ok    = (rp == '0) && (rc_s <= h_s);
        emit_sc   = row_ok && (cp == '0) && (cc_s <= w_s);
        last_kept = cc_2s > w_s;
        empty_row = row_ok && (scale_s > w_s) && (cc == '0);
        period_on = cfg.fix_period != '0;

        fc_inc    = {1'b0, fc} + (PER_W+1)'(1);
        fc_after  = (fc_inc >= {1'b0, cfg.fix_period}) ? '0 : fc_inc[PER_W-1:0];
        fc0       = (fc >= cfg.fix_period) ? '0 : fc;
        fc0_inc   = {1'b0, fc0} + (PER_W+1)'(1);
        fc_before = (fc0_inc >= {1'b0, cfg.fix_period}) ? '0 : fc0_inc[PER_W-1:0];

        cp_inc = {1'b0, cp} + (SCALE_W+1)'(1);
        rp_inc = {1'b0, rp} + (SCALE_W+1)'(1);

        emit              = 1'b0;
        dup               = 1'b0;
        column_count_next = cc;
        row_count_next    = rc;
        column_phase_next = cp;
        row_phase_next    = rp;
        fix_counter_next  = fc;
        image_done_next   = done;

        if (!done) begin
            if (geom.scaled) begin
                emit = emit_sc;
                if (emit_sc && last_kept && period_on) begin
                    fix_counter_next = fc_after;
                    dup              = fc_after == '0;
                end else if (empty_row && period_on) begin
                    fix_counter_next = fc_after;
                end
            end else begin
                emit = 1'b1;
                if (cc == '0 && period_on) begin
                    fix_counter_next = fc_before;
                    dup              = fc0 == '0;
                end
            end

            if (cc_1 >= w_s) begin
                column_count_next = '0;
                column_phase_next = '0;
                if (rc_1 >= h_s) begin
                    image_done_next = 1'b1;
                end else begin
                    row_count_next = RW'(rc_1);
                    row_phase_next = (rp_inc >= {1'b0, geom.scale}) ?
                                     '0 : rp_inc[SCALE_W-1:0];
                end
            end else begin
                column_count_next = CW'(cc_1);
                column_phase_next = (cp_inc >= {1'b0, geom.scale}) ?
                                    '0 : cp_inc[SCALE_W-1:0];
            end
        end
    end

    assign push            = accept && emit;
    assign push_entry.word = {s_red[7:3], s_green[7:2], s_blue[7:3]};
    assign push_entry.dup  = dup;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            column_phase_reg <= '0;
            row_phase_reg    <= '0;
            fix_counter_reg  <= '0;
            image_done_reg   <= 1'b0;
        end else begin
            if (accept) begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                column_phase_reg <= column_phase_next;
                row_phase_reg    <= row_phase_next;
                fix_counter_reg  <= fix_counter_next;
                image_done_reg   <= image_done_next;
            end
        end
    end

endmodule

>>> rtl/core/bdr_queue.sv
module bdr_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bdr_pkg::entry_t        push_entry,
    input  logic                   pop,
    output bdr_pkg::entry_t        head,
    output bdr_pkg::queue_status_t status
);
    import bdr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head              = mem_reg[rd_ptr_reg];
    assign status.full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign status.head_valid = count_reg != '0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/bdr_back.sv
module bdr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bdr_pkg::entry_t             head,
    input  bdr_pkg::queue_status_t      q_status,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bdr_pkg::WORD_W-1:0]  m_rgb565,
    output logic                        m_last
);
    import bdr_pkg::*;

    logic second_reg, second_next;
    logic first_of_two;

    assign first_of_two = head.dup && !second_reg;
    assign m_valid      = q_status.head_valid;
    assign m_rgb565     = head.word;
    assign m_last       = !first_of_two;
    assign pop          = m_valid && m_ready && !first_of_two;

    always_comb begin
        second_next = second_reg;
        if (m_valid && m_ready) begin
            second_next = first_of_two;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
        end
    end

endmodule

>>> rtl/core/bgr888_decimate_to_rgb565_unit.sv
// bgr888_decimate_to_rgb565_unit
// input channel s_*: one bgr888 source pixel per request in row-major order,
// s_first_pixel marks the first pixel of an image and restarts all counters.
// output channel m_*: rgb565 display words; m_last marks the final word
// produced by one source pixel (a repeated word comes as a pair).
// configuration: cfg_wr_en/cfg_index/cfg_wr_data write image width, image
// height, scale adjust and fix period; write only while the block is idle.
// queue path: a kept pixel is written into the queue when it is accepted.
// throughput: one source pixel per cycle while s_ready is high; the front
// classifies and counts, a 4-entry queue feeds the back, which sends one
// word per m_ready handshake, so a repeated word takes an extra handshake.
// stall: while m_ready is low the queue absorbs up to four kept pixels,
// then s_ready drops; dropped pixels never occupy the queue.
// reset: configuration returns to 160 x 128, adjust 1, fix off; counters
// and queue clear; the first pixel after reset starts an image.
module bgr888_decimate_to_rgb565_unit #(
    parameter int MAX_WIDTH  = bdr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bdr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bdr_pkg::COLOR_W-1:0] s_blue,
    input  logic [bdr_pkg::COLOR_W-1:0] s_green,
    input  logic [bdr_pkg::COLOR_W-1:0] s_red,
    input  logic                        s_first_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bdr_pkg::WORD_W-1:0]  m_rgb565,
    output logic                        m_last,
    input  logic                        cfg_wr_en,
    input  logic [bdr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bdr_pkg::DIM_W-1:0]   cfg_wr_data
);
    import bdr_pkg::*;

    cfg_t          cfg_reg;
    logic          q_push;
    logic          q_pop;
    entry_t        q_push_entry;
    entry_t        q_head;
    queue_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= RESET_CFG;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wr_data;
                REG_SCALE_ADJUST: cfg_reg.scale_adjust <= cfg_wr_data[ADJ_W-1:0];
                REG_FIX_PERIOD:   cfg_reg.fix_period   <= cfg_wr_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    bdr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_blue        (s_blue),
        .s_green       (s_green),
        .s_red         (s_red),
        .s_first_pixel (s_first_pixel),
        .q_status      (q_status),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    bdr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    bdr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rgb565 (m_rgb565),
        .m_last   (m_last)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    a_pop_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (m_valid && m_ready && m_last))
        else $error("queue popped before last word of a request");

    a_repeat_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_rgb565 == $past(m_rgb565)))
        else $error("repeated word missing after first of pair");

endmodule

>>> tb/bgr888_decimate_to_rgb565_unit_tb.sv
`timescale 1ns / 1ps

module bgr888_decimate_to_rgb565_unit_tb;
    import bdr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1150;

    typedef struct packed {
        logic [WORD_W-1:0] rgb565;
        logic              last;
    } display_word_t;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_PERIODIC} ready_mode_t;
    typedef enum int {SETUP_DIRECT, SETUP_TALL, SETUP_WIDE, SETUP_HUGE} setup_kind_t;

    class rgb565_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [ADJ_W-1:0] adjust_reg;
        logic [PER_W-1:0] period_reg;
        bit [9:0]         col;
        bit [9:0]         row;
        bit [9:0]         col_ph;
        bit [9:0]         row_ph;
        bit [PER_W-1:0]   fix_cnt;
        bit               done;
        display_word_t    pending_words[$];
        int               errors;

        function new();
            width_reg  = RESET_CFG.image_width;
            height_reg = RESET_CFG.image_height;
            adjust_reg = RESET_CFG.scale_adjust;
            period_reg = RESET_CFG.fix_period;
            col = 0; row = 0; col_ph = 0; row_ph = 0; fix_cnt = 0; done = 0;
            errors = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [DIM_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value;
                REG_IMAGE_HEIGHT: height_reg = value;
                REG_SCALE_ADJUST: adjust_reg = value[ADJ_W-1:0];
                REG_FIX_PERIOD:   period_reg = value[PER_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function bit advance_fix();
            fix_cnt = (fix_cnt + 1 >= period_reg) ? '0 : PER_W'(fix_cnt + 1);
            return fix_cnt == 0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] blue, green, red, logic first_pixel);
            int unsigned       w, h, scale, col_ratio, row_ratio;
            bit                scaled, emit, dup;
            logic [WORD_W-1:0] word;
            display_word_t     item;
            w = fit_dim(width_reg, DEF_MAX_WIDTH);
            h = fit_dim(height_reg, DEF_MAX_HEIGHT);
            scale = 1;
            emit = 0;
            dup = 0;
            scaled = (w > LIMIT_WIDTH) || (h > LIMIT_HEIGHT);
            if (first_pixel) begin
                col = 0; row = 0; col_ph = 0; row_ph = 0; fix_cnt = 0; done = 0;
            end
            if (done) return;
            word = {red[7:3], green[7:2], blue[7:3]};
            if (scaled) begin
                col_ratio = w / 160;
                row_ratio = h / 128;
                scale = ((col_ratio > row_ratio) ? col_ratio : row_ratio) + adjust_reg;
                if (scale == 0) scale = 1;
                if (row_ph == 0 && row + scale <= h && col_ph == 0 && col + scale <= w) begin
                    emit = 1;
                    // last kept pixel of the output row
                    if (col + 2 * scale > w && period_reg != 0) dup = advance_fix();
                end
                // empty output row still counts for the fix
                if (row_ph == 0 && row + scale <= h && scale > w && col == 0 &&
                    period_reg != 0)
                    void'(advance_fix());
            end else begin
                emit = 1;
                if (col == 0 && period_reg != 0) begin
                    if (fix_cnt >= period_reg) fix_cnt = 0;
                    dup = (fix_cnt == 0);
                    fix_cnt = (fix_cnt + 1 >= period_reg) ? '0 : PER_W'(fix_cnt + 1);
                end
            end
            if (emit) begin
                item.rgb565 = word;
                item.last = !dup;
                pending_words.push_back(item);
                if (dup) begin
                    item.last = 1'b1;
                    pending_words.push_back(item);
                end
            end
            if (col + 1 >= w) begin
                col = 0;
                col_ph = 0;
                if (row + 1 >= h) begin
                    done = 1;
                end else begin
                    row++;
                    row_ph = (row_ph + 1 >= scale) ? '0 : 10'(row_ph + 1);
                end
            end else begin
                col++;
                col_ph = (col_ph + 1 >= scale) ? '0 : 10'(col_ph + 1);
            end
        endfunction

        function void check_word(logic [WORD_W-1:0] rgb565, logic last);
            display_word_t want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h last %b", $time, rgb565, last);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (want.rgb565 !== rgb565) begin
                $display("%0t: rgb565 expected %h got %h", $time, want.rgb565, rgb565);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: last expected %b got %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    bit                 aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COLOR_W-1:0] s_blue;
    logic [COLOR_W-1:0] s_green;
    logic [COLOR_W-1:0] s_red;
    logic               s_first_pixel;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [WORD_W-1:0]  m_rgb565;
    logic               m_last;
    logic               cfg_wr_en;
    logic [IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]   cfg_wr_data;

    rgb565_scoreboard sb;
    int               cycles = 0;
    int               items_sent = 0;
    int               burst_left = 0;
    ready_mode_t      ready_mode = READY_ALWAYS;
    int               mode_left = 0;

    bgr888_decimate_to_rgb565_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_blue        (s_blue),
        .s_green       (s_green),
        .s_red         (s_red),
        .s_first_pixel (s_first_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgb565      (m_rgb565),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_pixel(s_blue, s_green, s_red, s_first_pixel);
            if (m_valid && m_ready) sb.check_word(m_rgb565, m_last);
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            default:        m_ready <= (mode_left % 5) >= 2;
        endcase
    end

    task automatic push_pixel(logic [COLOR_W-1:0] blue, green, red, logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_blue        <= blue;
        s_green       <= green;
        s_red         <= red;
        s_first_pixel <= first;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic send_image(int unsigned count, bit flag_first);
        for (int i = 0; i < count; i++) begin
            push_pixel(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                       (i == 0) && flag_first);
            items_sent++;
        end
    endtask

    // pixels past the end of an image
    task automatic send_trailing(int unsigned count);
        for (int i = 0; i < count; i++)
            push_pixel(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic load_setup(logic [DIM_W-1:0] w, h, logic [ADJ_W-1:0] adj,
                              logic [PER_W-1:0] per);
        cfg_index_t       idx;
        logic [DIM_W-1:0] data;
        wait_drained();
        for (int k = 0; k < 4; k++) begin
            idx = cfg_index_t'(k);
            case (idx)
                REG_IMAGE_WIDTH:  data = w;
                REG_IMAGE_HEIGHT: data = h;
                REG_SCALE_ADJUST: data = DIM_W'(adj);
                default:          data = DIM_W'(per);
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx;
            cfg_wr_data <= data;
            sb.write_register(idx, data);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase();
        setup_kind_t      kind;
        logic [DIM_W-1:0] w, h;
        logic [ADJ_W-1:0] adj;
        logic [PER_W-1:0] per;
        int unsigned      full, images, pick;
        kind = setup_kind_t'($urandom_range(0, 3));
        per = ($urandom_range(0, 3) == 0) ? PER_W'($urandom_range(0, 127))
                                           : PER_W'($urandom_range(0, 5));
        adj = ADJ_W'($urandom_range(0, 15));
        case (kind)
            SETUP_DIRECT: begin
                w = DIM_W'($urandom_range(1, 12));
                h = DIM_W'($urandom_range(1, 10));
                // mode boundary on the width
                if ($urandom_range(0, 5) == 0) begin
                    w = ($urandom_range(0, 1) != 0) ? DIM_W'(180) : DIM_W'(181);
                    h = DIM_W'($urandom_range(1, 2));
                    adj = ADJ_W'($urandom_range(0, 1));
                end
            end
            SETUP_TALL: begin
                w = DIM_W'($urandom_range(0, 3));
                h = DIM_W'($urandom_range(150, 156));
                if ($urandom_range(0, 3) != 0) adj = ADJ_W'($urandom_range(0, 2));
            end
            SETUP_WIDE: begin
                w = DIM_W'($urandom_range(180, 200));
                h = DIM_W'($urandom_range(0, 2));
                adj = ADJ_W'($urandom_range(0, 2));
            end
            default: begin
                w = ($urandom_range(0, 7) == 0) ? '0 : DIM_W'($urandom_range(900, 2047));
                h = ($urandom_range(0, 7) == 0) ? '0 : DIM_W'($urandom_range(900, 2047));
            end
        endcase
        load_setup(w, h, adj, per);
        if (kind == SETUP_HUGE) begin
            send_image($urandom_range(30, 100), 1'b1);
        end else begin
            full = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            images = (full > 200) ? 1 : $urandom_range(1, 3);
            repeat (images) begin
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    send_image($urandom_range(1, full), 1'b1);
                end else if (pick == 1) begin
                    send_image(full, 1'b0);
                end else begin
                    send_image(full, 1'b1);
                    if ($urandom_range(0, 3) == 0) send_trailing($urandom_range(1, 3));
                end
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_blue        = '0;
        s_green       = '0;
        s_red         = '0;
        s_first_pixel = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_wr_data   = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset setup, stream starts without a first flag
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
        push_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        items_sent += 4;
        // direct repeat every row, then pixels past the image
        load_setup(11'd2, 11'd2, 4'd1, 7'd1);
        send_image(4, 1'b1);
        send_trailing(2);
        // zero width, scaled by height
        load_setup(11'd0, 11'd151, 4'd0, 7'd2);
        send_image(5, 1'b1);
        // scale wider than the image: empty output rows
        load_setup(11'd2, 11'd151, 4'd2, 7'd3);
        send_image(6, 1'b1);
        // oversize clamp with the largest adjust and period
        load_setup(11'd2047, 11'd2047, 4'd15, 7'd127);
        send_image(4, 1'b1);

        while (items_sent < ITEM_TARGET) random_phase();

        wait_drained();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/bdr_pkg.sv
rtl/core/bdr_front.sv
rtl/core/bdr_queue.sv
rtl/core/bdr_back.sv
rtl/core/bgr888_decimate_to_rgb565_unit.sv
tb/bgr888_decimate_to_rgb565_unit_tb.sv
